@@ sv/evb_pkg.sv @@
//------------------------------------------------------------------------------
// evb_pkg
// Shared widths, register codes, command codes and payload types for the
// energy voice activity detector with barge-in.
//------------------------------------------------------------------------------
`default_nettype none

package evb_pkg;

	// Longest frame that is accumulated; later samples of a frame are dropped.
	localparam int MAX_FRAME = 1024;

	localparam int SMP_W   = 16;
	localparam int LVL_W   = 16;
	localparam int SQ_W    = 2 * SMP_W - 1;
	localparam int CNT_W   = $clog2(MAX_FRAME + 1);
	localparam int SUM_W   = SQ_W - 1 + CNT_W;
	localparam int NINE_W  = SUM_W + 4;
	localparam int PROD_W  = SQ_W + CNT_W;
	localparam int MULP_W  = SQ_W + LVL_W;
	localparam int FSV_W   = 16;
	localparam int BRUN_W  = 8;
	localparam int VRUN_W  = 2;

	// Q15 level of one; higher levels can never be reached.
	localparam logic [LVL_W:0] LVL_ONE = (LVL_W + 1)'(1 << (LVL_W - 1));
	localparam logic [VRUN_W-1:0] VRUN_ON  = VRUN_W'(3);
	localparam logic [FSV_W-1:0]  FSV_MAX  = '1;
	localparam logic [BRUN_W-1:0] BRUN_MAX = '1;

	// Audio channel commands.
	localparam logic CMD_AUDIO = 1'b0;
	localparam logic CMD_CLEAR = 1'b1;

	// Configuration port.
	localparam int PADDR_W   = 5;
	localparam int PDATA_W   = 32;
	localparam int REG_IDX_W = PADDR_W - 2;

	localparam logic [REG_IDX_W-1:0] REG_TRIGGER = REG_IDX_W'(0);
	localparam logic [REG_IDX_W-1:0] REG_STOP    = REG_IDX_W'(1);
	localparam logic [REG_IDX_W-1:0] REG_SILENCE = REG_IDX_W'(2);
	localparam logic [REG_IDX_W-1:0] REG_BARGE_EN = REG_IDX_W'(3);
	localparam logic [REG_IDX_W-1:0] REG_BARGE_FR = REG_IDX_W'(4);

	localparam logic [LVL_W-1:0]  RST_TRIGGER  = LVL_W'(16384);
	localparam logic [LVL_W-1:0]  RST_STOP     = LVL_W'(9830);
	localparam logic [FSV_W-1:0]  RST_SILENCE  = FSV_W'(100);
	localparam logic              RST_BARGE_EN = 1'b1;
	localparam logic [BRUN_W-1:0] RST_BARGE_FR = BRUN_W'(3);

	// Operand selection of the shared multiplier.
	localparam logic [1:0] MUL_SQ_TRIG = 2'd0;
	localparam logic [1:0] MUL_TIMES_N = 2'd1;
	localparam logic [1:0] MUL_SQ_STOP = 2'd2;

	typedef struct packed {
		logic                    cmd;
		logic signed [SMP_W-1:0] sample;
		logic                    last;
		logic                    playing;
	} in_item_t;

	typedef struct packed {
		logic speech_active;
		logic barge_in_event;
		logic barge_in_latched;
		logic frame_voiced;
		logic frame_quiet;
	} out_item_t;

	typedef struct packed {
		logic [LVL_W-1:0]  trigger_level;
		logic [LVL_W-1:0]  stop_level;
		logic [FSV_W-1:0]  silence_frames;
		logic              barge_enable;
		logic [BRUN_W-1:0] barge_frames;
	} cfg_t;

	typedef struct packed {
		logic       acc;
		logic       clr;
		logic       mul_en;
		logic [1:0] mul_op;
		logic       load_nine;
		logic       latch_voiced;
		logic       decide;
	} dp_cmd_t;

endpackage

`default_nettype wire

@@ sv/evb_in_if.sv @@
//------------------------------------------------------------------------------
// evb_in_if
// Input channel: one audio sample or clear command per beat.
//------------------------------------------------------------------------------
`default_nettype none

interface evb_in_if
	import evb_pkg::*;
();
	logic     valid;
	logic     ready;
	in_item_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

`default_nettype wire

@@ sv/evb_out_if.sv @@
//------------------------------------------------------------------------------
// evb_out_if
// Result channel: one detector result per closed frame.
//------------------------------------------------------------------------------
`default_nettype none

interface evb_out_if
	import evb_pkg::*;
();
	logic      valid;
	logic      ready;
	out_item_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

`default_nettype wire

@@ sv/evb_regs.sv @@
//------------------------------------------------------------------------------
// evb_regs
// APB register file holding the detector thresholds and barge-in settings.
//------------------------------------------------------------------------------
`default_nettype none

module evb_regs
	import evb_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [PADDR_W-1:0] paddr,
	input  wire logic [PDATA_W-1:0] pwdata,
	output logic      [PDATA_W-1:0] prdata,
	output logic                    pready,
	output cfg_t                    cfg
);

	logic [REG_IDX_W-1:0] idx;
	logic                 wr;
	cfg_t                 cfg_q;

	assign idx    = paddr[PADDR_W-1:2];
	assign wr     = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.trigger_level  <= RST_TRIGGER;
			cfg_q.stop_level     <= RST_STOP;
			cfg_q.silence_frames <= RST_SILENCE;
			cfg_q.barge_enable   <= RST_BARGE_EN;
			cfg_q.barge_frames   <= RST_BARGE_FR;
		end else if (wr) begin
			unique case (idx)
				REG_TRIGGER:  cfg_q.trigger_level  <= pwdata[LVL_W-1:0];
				REG_STOP:     cfg_q.stop_level     <= pwdata[LVL_W-1:0];
				REG_SILENCE:  cfg_q.silence_frames <= pwdata[FSV_W-1:0];
				REG_BARGE_EN: cfg_q.barge_enable   <= pwdata[0];
				REG_BARGE_FR: cfg_q.barge_frames   <= pwdata[BRUN_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_TRIGGER:  prdata = PDATA_W'(cfg_q.trigger_level);
			REG_STOP:     prdata = PDATA_W'(cfg_q.stop_level);
			REG_SILENCE:  prdata = PDATA_W'(cfg_q.silence_frames);
			REG_BARGE_EN: prdata = PDATA_W'(cfg_q.barge_enable);
			REG_BARGE_FR: prdata = PDATA_W'(cfg_q.barge_frames);
			default:      prdata = '0;
		endcase
	end

endmodule

`default_nettype wire

@@ sv/evb_ctrl.sv @@
//------------------------------------------------------------------------------
// evb_ctrl
// Sequencer: takes samples, then steps the shared multiplier through the
// two threshold compares and the frame-end update.
//------------------------------------------------------------------------------
`default_nettype none

module evb_ctrl
	import evb_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     in_valid,
	input  wire in_item_t in_item,
	output logic          in_ready,
	output logic          out_valid,
	input  wire logic     out_ready,
	output dp_cmd_t       cmd
);

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_SQ_T   = 3'd1;
	localparam logic [2:0] ST_MUL_T  = 3'd2;
	localparam logic [2:0] ST_SQ_S   = 3'd3;
	localparam logic [2:0] ST_MUL_S  = 3'd4;
	localparam logic [2:0] ST_DECIDE = 3'd5;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       out_valid_q;
	logic       take;
	logic       slot_free;

	assign in_ready  = (state_q == ST_IDLE);
	assign take      = in_valid && in_ready;
	assign slot_free = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (take) begin
					if (in_item.cmd == CMD_CLEAR) begin
						cmd.clr = 1'b1;
					end else begin
						cmd.acc = 1'b1;
						if (in_item.last) state_d = ST_SQ_T;
					end
				end
			end
			ST_SQ_T: begin
				cmd.mul_en    = 1'b1;
				cmd.mul_op    = MUL_SQ_TRIG;
				cmd.load_nine = 1'b1;
				state_d       = ST_MUL_T;
			end
			ST_MUL_T: begin
				cmd.mul_en = 1'b1;
				cmd.mul_op = MUL_TIMES_N;
				state_d    = ST_SQ_S;
			end
			ST_SQ_S: begin
				cmd.latch_voiced = 1'b1;
				cmd.mul_en       = 1'b1;
				cmd.mul_op       = MUL_SQ_STOP;
				state_d          = ST_MUL_S;
			end
			ST_MUL_S: begin
				cmd.mul_en = 1'b1;
				cmd.mul_op = MUL_TIMES_N;
				state_d    = ST_DECIDE;
			end
			ST_DECIDE: begin
				// Hold here until the result register can take the frame.
				if (slot_free) begin
					cmd.decide = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.decide) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

@@ sv/evb_dp.sv @@
//------------------------------------------------------------------------------
// evb_dp
// Datapath: energy accumulator, shared multiplier for the root-free level
// compares, hysteresis and barge-in state, and the result register.
//------------------------------------------------------------------------------
`default_nettype none

module evb_dp
	import evb_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire dp_cmd_t  cmd,
	input  wire cfg_t     cfg,
	input  wire in_item_t in_item,
	output out_item_t     result
);

	logic [SUM_W-1:0]  sum_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              playing_q;
	logic [NINE_W-1:0] nine_q;
	logic [PROD_W-1:0] prod_q;
	logic              voiced_q;
	logic [VRUN_W-1:0] vrun_q;
	logic              speech_q;
	logic [FSV_W-1:0]  fsv_q;
	logic [BRUN_W-1:0] brun_q;
	logic              barge_q;
	out_item_t         out_q;

	logic signed [2*SMP_W-1:0] sq_full;
	logic [SQ_W-1:0]           sq;
	logic [SQ_W-1:0]           mul_a;
	logic [LVL_W-1:0]          mul_b;
	logic [MULP_W-1:0]         mul_p;
	logic                      ge;
	logic                      trig_ok;
	logic                      stop_ok;
	logic                      quiet;
	logic [VRUN_W-1:0]         vrun_d;
	logic                      speech_d;
	logic [FSV_W-1:0]          fsv_d;
	logic [BRUN_W-1:0]         brun_d;
	logic                      barge_d;
	logic                      event_d;

	assign sq_full = in_item.sample * in_item.sample;
	assign sq      = sq_full[SQ_W-1:0];

	always_comb begin
		case (cmd.mul_op)
			MUL_SQ_TRIG: begin
				mul_a = SQ_W'(cfg.trigger_level);
				mul_b = cfg.trigger_level;
			end
			MUL_TIMES_N: begin
				mul_a = prod_q[SQ_W-1:0];
				mul_b = LVL_W'(cnt_q);
			end
			MUL_SQ_STOP: begin
				mul_a = SQ_W'(cfg.stop_level);
				mul_b = cfg.stop_level;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_p = MULP_W'(mul_a) * MULP_W'(mul_b);

	// 9*sum against level squared times count; levels above one never match.
	assign ge      = nine_q >= NINE_W'(prod_q);
	assign trig_ok = {1'b0, cfg.trigger_level} <= LVL_ONE;
	assign stop_ok = {1'b0, cfg.stop_level} <= LVL_ONE;
	assign quiet   = !(stop_ok && ge);

	always_comb begin
		vrun_d   = vrun_q;
		speech_d = speech_q;
		fsv_d    = (fsv_q != FSV_MAX) ? fsv_q + 1'b1 : fsv_q;
		brun_d   = brun_q;
		barge_d  = barge_q;
		event_d  = 1'b0;
		if (voiced_q) begin
			if (vrun_q != VRUN_ON) vrun_d = vrun_q + 1'b1;
			if (vrun_d == VRUN_ON && !speech_q) begin
				speech_d = 1'b1;
				fsv_d    = '0;
			end
		end else if (quiet) begin
			vrun_d = '0;
			if (speech_q && fsv_d >= cfg.silence_frames) speech_d = 1'b0;
		end
		if (speech_d && !quiet) fsv_d = '0;
		if (cfg.barge_enable && playing_q && speech_d) begin
			if (brun_q != BRUN_MAX) brun_d = brun_q + 1'b1;
			if (brun_d >= cfg.barge_frames && !barge_q) begin
				barge_d = 1'b1;
				event_d = 1'b1;
			end
		end else begin
			brun_d = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q     <= '0;
			cnt_q     <= '0;
			playing_q <= 1'b0;
			voiced_q  <= 1'b0;
			vrun_q    <= '0;
			speech_q  <= 1'b0;
			fsv_q     <= '0;
			brun_q    <= '0;
			barge_q   <= 1'b0;
		end else if (cmd.clr) begin
			sum_q    <= '0;
			cnt_q    <= '0;
			vrun_q   <= '0;
			speech_q <= 1'b0;
			fsv_q    <= '0;
			brun_q   <= '0;
			barge_q  <= 1'b0;
		end else begin
			if (cmd.acc) begin
				playing_q <= in_item.playing;
				if (cnt_q < CNT_W'(MAX_FRAME)) begin
					sum_q <= sum_q + SUM_W'(sq);
					cnt_q <= cnt_q + 1'b1;
				end
			end
			if (cmd.latch_voiced) voiced_q <= trig_ok && ge;
			if (cmd.decide) begin
				vrun_q   <= vrun_d;
				speech_q <= speech_d;
				fsv_q    <= fsv_d;
				brun_q   <= brun_d;
				barge_q  <= barge_d;
				sum_q    <= '0;
				cnt_q    <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_nine) nine_q <= (NINE_W'(sum_q) << 3) + NINE_W'(sum_q);
		if (cmd.mul_en) prod_q <= mul_p[PROD_W-1:0];
		if (cmd.decide) begin
			out_q.speech_active    <= speech_d;
			out_q.barge_in_event   <= event_d;
			out_q.barge_in_latched <= barge_d;
			out_q.frame_voiced     <= voiced_q;
			out_q.frame_quiet      <= quiet;
		end
	end

	assign result = out_q;

endmodule

`default_nettype wire

@@ sv/energy_vad_barge_in.sv @@
//------------------------------------------------------------------------------
// energy_vad_barge_in
// Energy voice activity detector with hysteresis and latched barge-in.
//------------------------------------------------------------------------------
// Channel  Direction  Beat
// audio    in         cmd, sample, last, playing (one sample or a clear)
// result   out        speech_active, barge_in_event, barge_in_latched,
//                     frame_voiced, frame_quiet (one per closed frame)
// apb      in/out     register writes and reads, no wait states
//
// A sample without last and a clear command leave the block ready for the next beat.
// A sample with last is accumulated, then takes four steps of the single shared
// multiplier for the two threshold compares and one update before the next beat.
// The update waits while the result register still holds an untaken beat;
// samples are otherwise accepted while a result waits.
// Reset clears all detector state and loads the register defaults.
//------------------------------------------------------------------------------
`default_nettype none

module energy_vad_barge_in
	import evb_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	evb_in_if.sink                  audio,
	evb_out_if.source               result,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [PADDR_W-1:0] paddr,
	input  wire logic [PDATA_W-1:0] pwdata,
	output logic      [PDATA_W-1:0] prdata,
	output logic                    pready
);

	cfg_t      cfg;
	dp_cmd_t   cmd;
	out_item_t res_item;
	logic      in_ready;
	logic      out_valid;

	evb_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	evb_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (audio.valid),
		.in_item   (audio.data),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (result.ready),
		.cmd       (cmd)
	);

	evb_dp u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.cfg     (cfg),
		.in_item (audio.data),
		.result  (res_item)
	);

	assign audio.ready  = in_ready;
	assign result.valid = out_valid;
	assign result.data  = res_item;

endmodule

`default_nettype wire

@@ dv/vad_frame_checker.sv @@
`timescale 1ns / 1ps
//------------------------------------------------------------------------------
// vad_frame_checker
// Watches the audio, result and register ports of the voice activity
// detector. It keeps its own copy of the detector state and registers,
// predicts the result of every closed frame and compares each result beat
// against the oldest prediction.
//------------------------------------------------------------------------------
module vad_frame_checker
	import evb_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	evb_in_if                  audio,
	evb_out_if                 result,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic               pready,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output int                 mismatches,
	output int                 frames_checked,
	output int                 frames_pending,
	output int                 speech_frames,
	output int                 barge_events
);

	// Square of the gain of three on rms, so the compare needs no root.
	localparam longint unsigned LEVEL_GAIN_SQ = 9;
	localparam int MAX_REPORTS = 10;

	cfg_t              regs;
	logic [SUM_W-1:0]  energy_acc;
	logic [CNT_W-1:0]  frame_len;
	logic [VRUN_W-1:0] loud_streak;
	logic              talking;
	logic [FSV_W-1:0]  since_voice;
	logic [BRUN_W-1:0] barge_streak;
	logic              barged;
	out_item_t         frame_verdicts[$];
	int                n_bad;
	int                n_checked;
	int                n_speech;
	int                n_barge;

	function automatic logic level_reached(input logic [LVL_W-1:0] lvl,
			input logic [SUM_W-1:0] sum, input logic [CNT_W-1:0] n);
		longint unsigned l;
		if (lvl > LVL_ONE) begin
			return 1'b0;
		end
		l = lvl;
		return LEVEL_GAIN_SQ * sum >= l * l * n;
	endfunction

	task automatic clear_detector();
		energy_acc   = '0;
		frame_len    = '0;
		loud_streak  = '0;
		talking      = 1'b0;
		since_voice  = '0;
		barge_streak = '0;
		barged       = 1'b0;
	endtask

	// Advances the detector by one audio beat and queues the verdict of a
	// frame that closes on it.
	task automatic track_voice_activity(input in_item_t beat);
		longint    s;
		logic      voiced;
		logic      quiet;
		logic      fired;
		out_item_t verdict;
		if (beat.cmd == CMD_CLEAR) begin
			clear_detector();
			return;
		end
		// Samples past the longest frame still count toward nothing.
		if (frame_len < CNT_W'(MAX_FRAME)) begin
			s = longint'($signed(beat.sample));
			energy_acc += SUM_W'(s * s);
			frame_len++;
		end
		if (!beat.last) begin
			return;
		end
		voiced = level_reached(regs.trigger_level, energy_acc, frame_len);
		quiet  = !level_reached(regs.stop_level, energy_acc, frame_len);
		fired  = 1'b0;
		if (since_voice != FSV_MAX) begin
			since_voice++;
		end
		if (voiced) begin
			if (loud_streak != VRUN_ON) begin
				loud_streak++;
			end
			if (loud_streak == VRUN_ON && !talking) begin
				talking     = 1'b1;
				since_voice = '0;
			end
		end else if (quiet) begin
			loud_streak = '0;
			if (talking && since_voice >= regs.silence_frames) begin
				talking = 1'b0;
			end
		end
		if (talking && !quiet) begin
			since_voice = '0;
		end
		if (regs.barge_enable && beat.playing && talking) begin
			if (barge_streak != BRUN_MAX) begin
				barge_streak++;
			end
			if (barge_streak >= regs.barge_frames && !barged) begin
				barged = 1'b1;
				fired  = 1'b1;
			end
		end else begin
			barge_streak = '0;
		end
		verdict.speech_active    = talking;
		verdict.barge_in_event   = fired;
		verdict.barge_in_latched = barged;
		verdict.frame_voiced     = voiced;
		verdict.frame_quiet      = quiet;
		frame_verdicts.insert(frame_verdicts.size(), verdict);
		energy_acc = '0;
		frame_len  = '0;
	endtask

	always @(posedge clk or negedge arst_n) begin
		out_item_t want;
		out_item_t got;
		if (!arst_n) begin
			clear_detector();
			regs.trigger_level  = RST_TRIGGER;
			regs.stop_level     = RST_STOP;
			regs.silence_frames = RST_SILENCE;
			regs.barge_enable   = RST_BARGE_EN;
			regs.barge_frames   = RST_BARGE_FR;
			frame_verdicts.delete();
			n_bad     = 0;
			n_checked = 0;
			n_speech  = 0;
			n_barge   = 0;
		end else begin
			// Results are matched before new beats are predicted, so a stray
			// result can never pair with a frame closing at the same edge.
			if (result.valid && result.ready) begin
				got = result.data;
				if (frame_verdicts.size() == 0) begin
					n_bad++;
					if (n_bad <= MAX_REPORTS) begin
						$display("%t: result beat with no frame waiting: speech %b event %b",
							$realtime, got.speech_active, got.barge_in_event);
					end
				end else begin
					want = frame_verdicts.pop_front();
					n_checked++;
					if (want.speech_active) begin
						n_speech++;
					end
					if (want.barge_in_event) begin
						n_barge++;
					end
					if (got !== want) begin
						n_bad++;
						if (n_bad <= MAX_REPORTS) begin
							$display("%t: frame %0d expected speech %b event %b latched %b %s",
								$realtime, n_checked, want.speech_active,
								want.barge_in_event, want.barge_in_latched, "");
							$display("    voiced %b quiet %b; got speech %b event %b latched %b %s%b %s%b",
								want.frame_voiced, want.frame_quiet, got.speech_active,
								got.barge_in_event, got.barge_in_latched,
								"voiced ", got.frame_voiced, "quiet ", got.frame_quiet);
						end
					end
				end
			end
			if (audio.valid && audio.ready) begin
				track_voice_activity(audio.data);
			end
			if (psel && penable && pwrite && pready) begin
				case (paddr[PADDR_W-1:2])
					REG_TRIGGER:  regs.trigger_level  = pwdata[LVL_W-1:0];
					REG_STOP:     regs.stop_level     = pwdata[LVL_W-1:0];
					REG_SILENCE:  regs.silence_frames = pwdata[FSV_W-1:0];
					REG_BARGE_EN: regs.barge_enable   = pwdata[0];
					REG_BARGE_FR: regs.barge_frames   = pwdata[BRUN_W-1:0];
					default: ;
				endcase
			end
		end
		mismatches     <= n_bad;
		frames_checked <= n_checked;
		frames_pending <= frame_verdicts.size();
		speech_frames  <= n_speech;
		barge_events   <= n_barge;
	end

endmodule

@@ dv/energy_vad_barge_in_test.sv @@
`timescale 1ns / 1ps
//------------------------------------------------------------------------------
// energy_vad_barge_in_test
// Drives the voice activity detector with directed frames at the level
// boundaries, then with random speech bursts, noise and clears under
// several register settings, while a checker predicts every frame result.
//------------------------------------------------------------------------------
module energy_vad_barge_in_test
	import evb_pkg::*;
();

	localparam int HALF_PERIOD     = 6;
	localparam int RESET_CYCLES    = 4;
	localparam int HOLD_OFF_CYCLES = 400;
	localparam int SETTLE_CYCLES   = 16;
	localparam int DRAIN_LIMIT     = 20000;

	typedef enum int {FK_LOUD, FK_MID, FK_SOFT, FK_SILENT, FK_WILD} frame_kind_t;
	typedef enum int {SINK_OPEN, SINK_CHOPPY, SINK_SLOW} sink_mode_t;

	logic               clk;
	logic               arst_n;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [PDATA_W-1:0] pwdata;
	logic [PDATA_W-1:0] prdata;
	logic               pready;

	int mismatches;
	int frames_checked;
	int frames_pending;
	int speech_frames;
	int barge_events;
	int beats_sent;
	int burst_left;
	int settings_used;
	int hold_off_asked;

	evb_in_if  audio();
	evb_out_if result();

	energy_vad_barge_in uut (
		.clk    (clk),
		.arst_n (arst_n),
		.audio  (audio),
		.result (result),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.pready (pready)
	);

	vad_frame_checker verdicts (
		.clk           (clk),
		.arst_n        (arst_n),
		.audio         (audio),
		.result        (result),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.pready        (pready),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.mismatches    (mismatches),
		.frames_checked(frames_checked),
		.frames_pending(frames_pending),
		.speech_frames (speech_frames),
		.barge_events  (barge_events)
	);

	initial begin
		clk = 1'b0;
		forever #HALF_PERIOD clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("FAILED: results differ");
		$finish;
	end

	// Sender: beats go out in bursts, separated by idle gaps with valid low.
	task automatic send_beat(input logic cmd, input logic signed [SMP_W-1:0] smp,
			input logic last, input logic playing);
		in_item_t beat;
		beat.cmd     = cmd;
		beat.sample  = smp;
		beat.last    = last;
		beat.playing = playing;
		if (burst_left == 0) begin
			audio.valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 200)
				: $urandom_range(1, 12);
		end
		audio.valid <= 1'b1;
		audio.data  <= beat;
		@(posedge clk);
		while (!audio.ready) @(posedge clk);
		burst_left--;
		beats_sent++;
	endtask

	// Waits until every closed frame has been answered and the block is idle.
	task automatic settle();
		audio.valid <= 1'b0;
		burst_left = 0;
		repeat (2) @(posedge clk);
		while (frames_pending != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input int unsigned value,
			input int width);
		logic [PDATA_W-1:0] mask;
		mask = (PDATA_W'(1) << width) - 1;
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		// Bits above the register width carry junk and must be dropped.
		pwdata  <= (PDATA_W'($urandom()) & ~mask) | (PDATA_W'(value) & mask);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	task automatic configure(input int unsigned trig, input int unsigned stop,
			input int unsigned silence, input int unsigned barge_en, input int unsigned barge_fr);
		write_reg(REG_TRIGGER, trig, LVL_W);
		write_reg(REG_STOP, stop, LVL_W);
		write_reg(REG_SILENCE, silence, FSV_W);
		write_reg(REG_BARGE_EN, barge_en, 1);
		write_reg(REG_BARGE_FR, barge_fr, BRUN_W);
		settings_used++;
	endtask

	function automatic logic signed [SMP_W-1:0] pick_sample(input frame_kind_t kind);
		logic [SMP_W-1:0] mag;
		case (kind)
			FK_LOUD: begin
				if ($urandom_range(0, 7) == 0) begin
					return 16'sh8000;
				end
				mag = SMP_W'($urandom_range(12000, 32767));
			end
			FK_MID:    mag = SMP_W'($urandom_range(3000, 11000));
			FK_SOFT:   mag = SMP_W'($urandom_range(1, 2500));
			FK_SILENT: mag = SMP_W'($urandom_range(0, 40));
			default:   return SMP_W'($urandom());
		endcase
		return $urandom_range(0, 1) ? -mag : mag;
	endfunction

	function automatic int pick_frame_len();
		return ($urandom_range(0, 7) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 6);
	endfunction

	function automatic int unsigned pick_level();
		case ($urandom_range(0, 3))
			0:       return 0;
			1:       return 32768;
			2:       return $urandom_range(32769, 65535);
			default: return $urandom_range(1000, 32767);
		endcase
	endfunction

	// Playback only counts on the beat that closes the frame.
	task automatic send_frame(input frame_kind_t kind, input int len, input logic playing);
		for (int i = 0; i < len; i++) begin
			send_beat(CMD_AUDIO, pick_sample(kind), i == len - 1,
				(i == len - 1) ? playing : 1'($urandom_range(0, 1)));
		end
	endtask

	// Mostly speech bursts followed by quiet tails, with noise and clears mixed in.
	task automatic run_traffic(input int beats);
		int   target;
		int   scene;
		logic play;
		target = beats_sent + beats;
		while (beats_sent < target) begin
			scene = $urandom_range(0, 9);
			if (scene <= 4) begin
				play = ($urandom_range(0, 3) != 0);
				repeat ($urandom_range(2, 7)) begin
					send_frame(FK_LOUD, pick_frame_len(), play && ($urandom_range(0, 7) != 0));
				end
				repeat ($urandom_range(1, 8)) begin
					send_frame($urandom_range(0, 1) ? FK_SOFT : FK_SILENT, pick_frame_len(), play);
				end
			end else if (scene <= 6) begin
				send_frame(frame_kind_t'($urandom_range(0, 4)), pick_frame_len(),
					1'($urandom_range(0, 1)));
			end else if (scene == 7) begin
				repeat ($urandom_range(1, 4)) begin
					send_frame(FK_MID, pick_frame_len(), 1'($urandom_range(0, 1)));
				end
			end else begin
				// A clear may cut a frame short.
				if (scene == 8) begin
					repeat ($urandom_range(1, 5)) begin
						send_beat(CMD_AUDIO, pick_sample(FK_LOUD), 1'b0, 1'($urandom_range(0, 1)));
					end
				end
				send_beat(CMD_CLEAR, SMP_W'($urandom()), 1'($urandom_range(0, 1)),
					1'($urandom_range(0, 1)));
			end
		end
	endtask

	// Receiver: changes its stall pattern every so often and holds off for a
	// long stretch whenever the stimulus asks for it.
	initial begin : result_sink
		sink_mode_t mode;
		int         mode_left;
		int         hold_off_done;
		result.ready <= 1'b0;
		mode = SINK_OPEN;
		mode_left = 0;
		hold_off_done = 0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (hold_off_asked > hold_off_done) begin
				hold_off_done++;
				result.ready <= 1'b0;
				repeat (HOLD_OFF_CYCLES) @(posedge clk);
			end
			if (mode_left == 0) begin
				mode = sink_mode_t'($urandom_range(0, 2));
				mode_left = $urandom_range(20, 150);
			end
			mode_left--;
			case (mode)
				SINK_OPEN:   result.ready <= 1'b1;
				SINK_CHOPPY: result.ready <= 1'($urandom_range(0, 1));
				default:     result.ready <= ($urandom_range(0, 5) == 0);
			endcase
		end
	end

	initial begin : stimulus
		int waited;
		arst_n      <= 1'b0;
		psel        <= 1'b0;
		penable     <= 1'b0;
		pwrite      <= 1'b0;
		paddr       <= '0;
		pwdata      <= '0;
		audio.valid <= 1'b0;
		audio.data  <= '0;
		beats_sent = 0;
		burst_left = 0;
		settings_used = 1;
		hold_off_asked = 0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed frames under the reset settings.
		send_beat(CMD_AUDIO, 16'sh8000, 1'b0, 1'b0);
		send_beat(CMD_AUDIO, 16'sh7FFF, 1'b1, 1'b1);
		send_beat(CMD_AUDIO, 16'sd0, 1'b1, 1'b0);
		send_beat(CMD_CLEAR, 16'sh5A5A, 1'b1, 1'b1);
		// Three loud frames turn speech on, two more raise barge-in.
		repeat (6) send_beat(CMD_AUDIO, 16'sh8000, 1'b1, 1'b1);
		send_beat(CMD_AUDIO, 16'sd1, 1'b1, 1'b0);
		// A clear in the middle of a frame drops the partial sum.
		send_beat(CMD_AUDIO, 16'sh7FFF, 1'b0, 1'b1);
		send_beat(CMD_CLEAR, 16'shFFFF, 1'b0, 1'b0);
		send_beat(CMD_AUDIO, 16'shFFFF, 1'b1, 1'b0);
		// Single samples just above and below the trigger and stop levels.
		send_beat(CMD_AUDIO, 16'sd5462, 1'b1, 1'b1);
		send_beat(CMD_AUDIO, 16'sd5461, 1'b1, 1'b1);
		send_beat(CMD_AUDIO, -16'sd5462, 1'b1, 1'b1);
		send_beat(CMD_AUDIO, -16'sd3276, 1'b1, 1'b0);
		send_beat(CMD_AUDIO, -16'sd3277, 1'b1, 1'b0);
		settle();

		configure(16384, 9830, 2, 1, 0);
		hold_off_asked++;
		run_traffic(100);
		settle();

		// Every frame voiced, none quiet.
		configure(0, 0, 0, 1, 1);
		run_traffic(70);
		settle();

		// Levels above one: never voiced, always quiet.
		configure(65535, 65535, 65535, 0, 255);
		run_traffic(70);
		settle();

		configure(32768, 32768, 1, 1, 2);
		hold_off_asked++;
		run_traffic(80);
		settle();

		repeat (2) begin
			configure(pick_level(), pick_level(),
				$urandom_range(0, 1) ? $urandom_range(0, 6) : $urandom_range(0, 65535),
				($urandom_range(0, 3) != 0),
				($urandom_range(0, 3) == 0) ? $urandom_range(5, 255) : $urandom_range(0, 4));
			run_traffic(90);
			settle();
		end

		configure(32768, 16384, 3, 1, 3);
		run_traffic(20);

		audio.valid <= 1'b0;
		repeat (2) @(posedge clk);
		waited = 0;
		while (frames_pending != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("Run covered %0d audio beats over %0d register settings, %0d frames checked.",
			beats_sent, settings_used, frames_checked);
		$display("Speech was on in %0d frames, %0d barge-ins were raised, %0d long stalls.",
			speech_frames, barge_events, hold_off_asked);
		if (mismatches == 0 && frames_pending == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule
